>>> design/bsc_pkg.sv
// Package for the barometric compensation core: register indexes and the
// coefficient bundle type shared by the pipeline modules. No dependencies.
package bsc_pkg;

  localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

  localparam int CFG_W = 64;
  localparam int DIV_W = 64;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] plow;
    logic [63:0] phigh;
    logic [15:0] p9;
  } coeffs_t;

endpackage

>>> design/bsc_divider.sv
// Pipelined signed 64-bit restoring divider, one quotient bit per stage.
// Depends on bsc_pkg. Carries a side payload alongside each beat.
module bsc_divider
  import bsc_pkg::*;
#(
  parameter int SIDE_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [DIV_W-1:0]        in_num,
  input  logic [DIV_W-1:0]        in_den,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_vld,
  output logic [DIV_W-1:0]        out_quo,
  output logic [SIDE_W-1:0]       out_side
);

  logic                vld_r  [DIV_W+1];
  logic [DIV_W-1:0]    rem_r  [DIV_W+1];
  logic [DIV_W-1:0]    quo_r  [DIV_W+1];
  logic [DIV_W-1:0]    den_r  [DIV_W+1];
  logic                neg_r  [DIV_W+1];
  logic [SIDE_W-1:0]   side_r [DIV_W+1];

  // entry stage: take magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
    rem_r[0]  <= '0;
    quo_r[0]  <= in_num[DIV_W-1] ? (DIV_W'(0) - in_num) : in_num;
    den_r[0]  <= in_den[DIV_W-1] ? (DIV_W'(0) - in_den) : in_den;
    neg_r[0]  <= in_num[DIV_W-1] ^ in_den[DIV_W-1];
    side_r[0] <= in_side;
  end

  // one quotient bit per stage; quo_r shifts dividend bits out, result in
  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    assign trial = {rem_r[i], quo_r[i][DIV_W-1]};
    assign diff  = trial - {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
      if (!diff[DIV_W]) begin
        rem_r[i+1] <= diff[DIV_W-1:0];
        quo_r[i+1] <= {quo_r[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= trial[DIV_W-1:0];
        quo_r[i+1] <= {quo_r[i][DIV_W-2:0], 1'b0};
      end
      den_r[i+1]  <= den_r[i];
      neg_r[i+1]  <= neg_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[DIV_W];
  assign out_quo  = neg_r[DIV_W] ? (DIV_W'(0) - quo_r[DIV_W]) : quo_r[DIV_W];
  assign out_side = side_r[DIV_W];

endmodule

>>> design/bsc_front.sv
// Front pipeline: temperature path, t_fine, dividend and divisor forming.
// Depends on bsc_pkg. Each multiply is followed by a register.
module bsc_front
  import bsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [19:0]  in_raw_t,
  input  logic [19:0]  in_raw_p,
  input  coeffs_t      co,
  output logic         out_vld,
  output logic [63:0]  out_num,
  output logic [63:0]  out_den,
  output logic [23:0]  out_temp
);

  logic signed [31:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6;
  assign t1 = 32'($unsigned(co.temp[15:0]));
  assign t2 = 32'($signed(co.temp[31:16]));
  assign t3 = 32'($signed(co.temp[47:32]));
  assign p1 = 64'($unsigned(co.plow[15:0]));
  assign p2 = 64'($signed(co.plow[31:16]));
  assign p3 = 64'($signed(co.plow[47:32]));
  assign p4 = 64'($signed(co.plow[63:48]));
  assign p5 = 64'($signed(co.phigh[15:0]));
  assign p6 = 64'($signed(co.phigh[31:16]));

  logic [5:0] v_r;

  // s1: differences
  logic [31:0] d1_r, d2_r; logic [19:0] rp1_r;
  always_ff @(posedge clk) begin
    d1_r  <= 32'({12'd0, in_raw_t[19:3]}) - (t1 <<< 1);
    d2_r  <= 32'({12'd0, in_raw_t[19:4]}) - t1;
    rp1_r <= in_raw_p;
  end
  // s2: products
  logic signed [31:0] m1_r, sq_r; logic [19:0] rp2_r;
  always_ff @(posedge clk) begin
    m1_r  <= 32'($signed(d1_r) * t2);
    sq_r  <= 32'($signed(d2_r) * $signed(d2_r));
    rp2_r <= rp1_r;
  end
  // s3: v2 product
  logic signed [31:0] v1_r, m3_r; logic [19:0] rp3_r;
  always_ff @(posedge clk) begin
    v1_r  <= m1_r >>> 11;
    m3_r  <= 32'((sq_r >>> 12) * t3);
    rp3_r <= rp2_r;
  end
  // s4: t_fine; temperature and a are formed from it combinationally
  logic signed [31:0] tf_r; logic [19:0] rp4_r;
  always_ff @(posedge clk) begin
    tf_r  <= v1_r + (m3_r >>> 14);
    rp4_r <= rp3_r;
  end
  logic signed [31:0] tmp32;
  assign tmp32 = (32'(tf_r * 32'sd5) + 32'sd128) >>> 8;
  // s5: a and squares
  logic signed [63:0] a_r, aa_r; logic [23:0] t5_r; logic [19:0] rp5_r;
  logic signed [63:0] a_c;
  assign a_c = 64'(tf_r) - 64'sd128000;
  always_ff @(posedge clk) begin
    a_r  <= a_c;
    aa_r <= a_c * a_c;
    t5_r <= tmp32[23:0];
    rp5_r <= rp4_r;
  end
  // s6: coefficient products
  logic signed [63:0] b_r, x_r; logic [23:0] t6_r; logic [19:0] rp6_r;
  always_ff @(posedge clk) begin
    b_r  <= aa_r * p6 + ((a_r * p5) <<< 17) + (p4 <<< 35);
    x_r  <= ((aa_r * p3) >>> 8) + ((a_r * p2) <<< 12);
    t6_r <= t5_r;
    rp6_r <= rp5_r;
  end
  // s7: divisor and dividend
  logic [63:0] num_r, den_r; logic [23:0] t7_r;
  logic [63:0] pm;
  assign pm = 64'd1048576 - 64'(rp6_r);
  always_ff @(posedge clk) begin
    den_r <= 64'(((64'sd1 <<< 47) + x_r) * p1 >>> 33);
    num_r <= ((pm << 31) - b_r) * 64'd3125;
    t7_r  <= t6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[4:0], in_vld};
  end
  logic v7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v_r[5];
  end

  assign out_vld  = v7_r;
  assign out_num  = num_r;
  assign out_den  = den_r;
  assign out_temp = t7_r;

endmodule

>>> design/bsc_back.sv
// Back pipeline: P7..P9 correction after the quotient, final scaling.
// Depends on bsc_pkg.
module bsc_back
  import bsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [63:0]  in_quo,
  input  logic [24:0]  in_side,
  input  coeffs_t      co,
  output logic         out_vld,
  output logic [23:0]  out_temp,
  output logic [23:0]  out_press,
  output logic         out_inval
);

  logic signed [63:0] p7, p8, p9;
  assign p7 = 64'($signed(co.phigh[47:32]));
  assign p8 = 64'($signed(co.phigh[63:48]));
  assign p9 = 64'($signed(co.p9));

  logic [3:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[2:0], in_vld};
  end

  // b1: ps, p8 product
  logic signed [63:0] p_a, ps_a, d_a; logic [24:0] s_a;
  always_ff @(posedge clk) begin
    p_a  <= $signed(in_quo);
    ps_a <= $signed(in_quo) >>> 13;
    d_a  <= (p8 * $signed(in_quo)) >>> 19;
    s_a  <= in_side;
  end
  // b2: p9 * ps
  logic signed [63:0] p_b, ps_b, d_b, m_b; logic [24:0] s_b;
  always_ff @(posedge clk) begin
    p_b <= p_a; ps_b <= ps_a; d_b <= d_a; s_b <= s_a;
    m_b <= p9 * ps_a;
  end
  // b3: low 64 bits of m * ps from 32-bit partial products
  logic signed [63:0] p_c, d_c; logic [63:0] ll_c; logic [31:0] x_c;
  logic [24:0] s_c;
  always_ff @(posedge clk) begin
    p_c  <= p_b; d_c <= d_b; s_c <= s_b;
    ll_c <= 64'(m_b[31:0]) * 64'(ps_b[31:0]);
    x_c  <= 32'(m_b[63:32] * ps_b[31:0]) + 32'(m_b[31:0] * ps_b[63:32]);
  end
  // b4: recombine, sum and scale
  logic signed [63:0] c_w; logic signed [63:0] f;
  logic [23:0] pr_r; logic [24:0] s_d;
  assign c_w = $signed(ll_c + {x_c, 32'd0}) >>> 25;
  assign f = ((p_c + c_w + d_c) >>> 8) + (p7 <<< 4);
  always_ff @(posedge clk) begin
    pr_r <= s_c[24] ? 24'd0 : f[31:8];
    s_d  <= s_c;
  end

  assign out_vld   = v_r[3];
  assign out_temp  = s_d[23:0];
  assign out_press = pr_r;
  assign out_inval = s_d[24];

endmodule

>>> design/barometric_sensor_compensation_core.sv
// Top level of the barometric compensation core: config registers and the
// front, divider and back pipelines. Depends on bsc_pkg and the bsc_ modules.
//
//  channel | ports                          | beat marked by
//  --------+--------------------------------+----------------------
//  input   | in_raw_temperature/pressure    | start && !busy
//  result  | out_temperature_centi, ...     | out_strobe (one cycle)
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// One sample pair per cycle, through the front, the one-bit-per-stage 64-bit
// divider and the back pipelines. busy is always low. Reset is synchronous
// and clears valid bits and coefficients. The receiver cannot stall.
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [19:0]       in_raw_temperature,
  input  logic [19:0]       in_raw_pressure,
  output logic              out_strobe,
  output logic [23:0]       out_temperature_centi,
  output logic [23:0]       out_pressure_pa,
  output logic              out_pressure_invalid,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  coeffs_t co_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) co_r <= '0;
    else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_COEFFS: co_r.temp  <= cfg_data[47:0];
        REG_PRESS_LOW:   co_r.plow  <= cfg_data;
        REG_PRESS_HIGH:  co_r.phigh <= cfg_data;
        REG_PRESS_NINE:  co_r.p9    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic f_vld; logic [63:0] f_num, f_den; logic [23:0] f_temp;
  bsc_front u_front (
    .clk, .rst_n, .in_vld(start && !busy), .in_raw_t(in_raw_temperature),
    .in_raw_p(in_raw_pressure), .co(co_r), .out_vld(f_vld), .out_num(f_num),
    .out_den(f_den), .out_temp(f_temp)
  );

  logic d_vld; logic [63:0] d_quo; logic [24:0] d_side;
  bsc_divider #(.SIDE_W(25)) u_div (
    .clk, .rst_n, .in_vld(f_vld), .in_num(f_num),
    .in_den((f_den == 64'd0) ? 64'd1 : f_den),
    .in_side({f_den == 64'd0, f_temp}), .out_vld(d_vld), .out_quo(d_quo),
    .out_side(d_side)
  );

  bsc_back u_back (
    .clk, .rst_n, .in_vld(d_vld), .in_quo(d_quo), .in_side(d_side), .co(co_r),
    .out_vld(out_strobe), .out_temp(out_temperature_centi),
    .out_press(out_pressure_pa), .out_inval(out_pressure_invalid)
  );

  a_inval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_pressure_invalid |-> out_pressure_pa == 24'd0)
    else $error("invalid pressure not zero");
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld |-> ##4 out_strobe)
    else $error("divider beat lost");

endmodule
